// ===== src/lbpg_pkg.sv =====
package lbpg_pkg;

    // Pattern codes as carried by a pattern-change request.
    typedef enum logic [2:0] {
        PAT_OFF   = 3'd0,
        PAT_ON    = 3'd1,
        PAT_SLOW  = 3'd2,
        PAT_FAST  = 3'd3,
        PAT_HEART = 3'd4,
        PAT_ERROR = 3'd5
    } t_pattern;

    // Request kinds carried in tuser.
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_PERIOD  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEART_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ERROR_PERIOD = 2'd3;

    localparam int unsigned PERIOD_BITS = 16;
    localparam logic [PERIOD_BITS-1:0] SLOW_PERIOD_RST  = 16'd500;
    localparam logic [PERIOD_BITS-1:0] FAST_PERIOD_RST  = 16'd100;
    localparam logic [PERIOD_BITS-1:0] HEART_PERIOD_RST = 16'd150;
    localparam logic [PERIOD_BITS-1:0] ERROR_PERIOD_RST = 16'd80;

    // Step counts of the multi-step patterns.
    localparam int unsigned STEP_BITS = 4;
    localparam logic [STEP_BITS:0] HEART_STEPS = 5'd6;
    localparam logic [STEP_BITS:0] ERROR_STEPS = 5'd10;

    // Field widths of the stream payload.
    localparam int unsigned IN_TIME_BITS = 32;
    localparam int unsigned S_TDATA_BITS = 40;
    localparam int unsigned M_TDATA_BITS = 8;

    // Pattern state apart from the step time stamp.
    typedef struct packed {
        t_pattern              pattern;
        logic                  led;
        logic [STEP_BITS-1:0]  step;
    } t_led_state;

    // Programmed step periods.
    typedef struct packed {
        logic [PERIOD_BITS-1:0] slow;
        logic [PERIOD_BITS-1:0] fast;
        logic [PERIOD_BITS-1:0] heart;
        logic [PERIOD_BITS-1:0] error;
    } t_periods;

endpackage

// ===== src/lbpg_step.sv =====
module lbpg_step
    import lbpg_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_mode,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [2:0]           i_pattern,
    input  t_periods             i_periods,
    input  t_led_state           i_state,
    input  logic [TIME_BITS-1:0] i_last_time,
    output t_led_state           o_state,
    output logic [TIME_BITS-1:0] o_last_time
);

    logic [TIME_BITS-1:0]   w_diff;
    logic [PERIOD_BITS-1:0] w_period;
    logic                   w_elapsed;
    logic [STEP_BITS:0]     w_step_inc;
    logic [STEP_BITS-1:0]   w_heart_step;
    logic [STEP_BITS-1:0]   w_error_step;

    // Elapsed time since the last step, wrapping at the time width.
    assign w_diff = i_now - i_last_time;

    always_comb begin
        case (i_state.pattern)
            PAT_SLOW:  w_period = i_periods.slow;
            PAT_FAST:  w_period = i_periods.fast;
            PAT_HEART: w_period = i_periods.heart;
            PAT_ERROR: w_period = i_periods.error;
            default:   w_period = '0;
        endcase
    end

    assign w_elapsed = (w_diff >= TIME_BITS'(w_period));

    // Next step of the heartbeat and error sequences.
    assign w_step_inc   = {1'b0, i_state.step} + 1'b1;
    assign w_heart_step = (w_step_inc >= HEART_STEPS) ? '0 : w_step_inc[STEP_BITS-1:0];
    assign w_error_step = (w_step_inc >= ERROR_STEPS) ? '0 : w_step_inc[STEP_BITS-1:0];

    // Next state for one request.
    always_comb begin
        o_state     = i_state;
        o_last_time = i_last_time;
        if (i_mode == MODE_SELECT) begin
            // Undefined codes and the active pattern leave everything as it is.
            if (i_pattern <= 3'(PAT_ERROR) && i_pattern != i_state.pattern) begin
                o_state.pattern = t_pattern'(i_pattern);
                o_state.step    = '0;
                o_last_time     = i_now;
            end
        end else begin
            case (i_state.pattern)
                PAT_OFF: begin
                    o_state.led = 1'b0;
                end
                PAT_ON: begin
                    o_state.led = 1'b1;
                end
                PAT_SLOW, PAT_FAST: begin
                    if (w_elapsed) begin
                        o_last_time = i_now;
                        o_state.led = ~i_state.led;
                    end
                end
                PAT_HEART: begin
                    if (w_elapsed) begin
                        o_last_time  = i_now;
                        o_state.step = w_heart_step;
                        o_state.led  = (w_heart_step == 4'd0) || (w_heart_step == 4'd2);
                    end
                end
                PAT_ERROR: begin
                    if (w_elapsed) begin
                        o_last_time  = i_now;
                        o_state.step = w_error_step;
                        o_state.led  = (w_error_step == 4'd0) || (w_error_step == 4'd2)
                                    || (w_error_step == 4'd4);
                    end
                end
                default: begin
                    o_state = i_state;
                end
            endcase
        end
    end

endmodule

// ===== src/led_blink_pattern_generator_unit.sv =====
// Status LED blink pattern generator.
//
// Requests arrive on the slave stream. tuser selects the kind: a time tick
// (tick time in tdata) or a pattern change (new pattern and current time).
// Every request yields one result on the master stream carrying the LED
// level after that request was applied.
// The step periods are set through the write port (index, data, enable);
// write them only while no request is in flight, the block does not enforce it.
//
// A request accepted from the slave stream is held in the input register,
// then applied to the pattern state as its result is written to the result
// register. One request per cycle is sustained while the receiver takes
// results; the state update is a single subtract, compare and step increment.
// Reset returns the periods to 500, 100, 150 and 80 ms, the pattern to off,
// the LED to dark and empties both registers. When the receiver stalls the
// result holds, the input register fills, and tready drops after one more
// request until the result is taken.
module led_blink_pattern_generator_unit
    import lbpg_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [PERIOD_BITS-1:0]    i_cfg_wdata,
    // Request stream.
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [S_TDATA_BITS-1:0]   i_s_axis_tdata,  // time_ms[31:0], pattern[34:32], zero
    input  logic                      i_s_axis_tuser,  // mode
    // Result stream.
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [M_TDATA_BITS-1:0]   o_m_axis_tdata   // led_on[0], zero
);

    localparam int unsigned EXT_BITS = TIME_BITS + IN_TIME_BITS;

    t_periods               r_periods;
    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [TIME_BITS-1:0]   r_in_time;
    logic [2:0]             r_in_pattern;
    t_led_state             r_state;
    t_led_state             n_state;
    logic [TIME_BITS-1:0]   r_last_time;
    logic [TIME_BITS-1:0]   n_last_time;
    logic                   r_out_valid;
    logic                   r_out_led;
    logic                   w_adv;
    logic                   w_in_take;
    logic [EXT_BITS-1:0]    w_time_ext;

    // Time taken modulo the internal time width.
    assign w_time_ext = EXT_BITS'(i_s_axis_tdata[IN_TIME_BITS-1:0]);

    // The result register can take a new value when empty or being drained.
    assign w_adv           = ~r_out_valid | i_m_axis_tready;
    assign o_s_axis_tready = ~r_in_valid | w_adv;
    assign w_in_take       = i_s_axis_tvalid & o_s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods.slow  <= SLOW_PERIOD_RST;
            r_periods.fast  <= FAST_PERIOD_RST;
            r_periods.heart <= HEART_PERIOD_RST;
            r_periods.error <= ERROR_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOW_PERIOD:  r_periods.slow  <= i_cfg_wdata;
                CFG_FAST_PERIOD:  r_periods.fast  <= i_cfg_wdata;
                CFG_HEART_PERIOD: r_periods.heart <= i_cfg_wdata;
                CFG_ERROR_PERIOD: r_periods.error <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_mode    <= i_s_axis_tuser;
            r_in_time    <= w_time_ext[TIME_BITS-1:0];
            r_in_pattern <= i_s_axis_tdata[IN_TIME_BITS+2:IN_TIME_BITS];
        end
    end

    // Pattern state update for the registered request.
    lbpg_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_mode      (r_in_mode),
        .i_now       (r_in_time),
        .i_pattern   (r_in_pattern),
        .i_periods   (r_periods),
        .i_state     (r_state),
        .i_last_time (r_last_time),
        .o_state     (n_state),
        .o_last_time (n_last_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pattern <= PAT_OFF;
            r_state.led     <= 1'b0;
            r_state.step    <= '0;
            r_last_time     <= '0;
        end else if (r_in_valid && w_adv) begin
            r_state     <= n_state;
            r_last_time <= n_last_time;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_adv) begin
            r_out_led <= n_state.led;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_BITS'(r_out_led);

    // A tick under the off pattern darkens the LED.
    a_off_dark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && r_in_mode == MODE_TICK && r_state.pattern == PAT_OFF)
        |=> !r_out_led)
        else $error("off pattern tick left LED lit");

    // A tick under the on pattern lights the LED.
    a_on_lit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && r_in_mode == MODE_TICK && r_state.pattern == PAT_ON)
        |=> r_out_led)
        else $error("on pattern tick left LED dark");

    // A pattern change never moves the LED level.
    a_select_keeps_led : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && r_in_mode == MODE_SELECT)
        |=> (r_state.led == $past(r_state.led)) && (r_out_led == $past(r_state.led)))
        else $error("pattern change altered LED level");

    // The step counter stays within the longest sequence.
    a_step_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_state.step} < ERROR_STEPS)
        else $error("step index out of range");

    // A change to another pattern restarts the sequence at its first step.
    a_select_clears_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && r_in_mode == MODE_SELECT && r_in_pattern != r_state.pattern
         && r_in_pattern <= 3'(PAT_ERROR))
        |=> (r_state.step == '0) && (r_last_time == $past(r_in_time)))
        else $error("pattern change did not restart the sequence");

endmodule
